@@ sv/stpl_pkg.sv @@
// shared types and constants for the sweep table packet loader
`default_nettype none
package stpl_pkg;
  localparam int TableDepthDefault = 128;
  localparam int PacketBytesDefault = 64;
  localparam int PreambleLen = 10;
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PARSE, ST_SCAN, ST_CLEAR, ST_REPLY, ST_READ
  } stpl_state_t;

  typedef struct packed {
    logic store_byte;
    logic parse;
    logic scan_start;
    logic scan_step;
    logic clear_step;
    logic reply_start;
    logic reply_step;
    logic read_entry;
  } stpl_cmd_t;

  typedef struct packed {
    logic packet_done;
    logic do_scan;
    logic scan_done;
    logic scan_ok;
    logic clear_done;
    logic reply_done;
  } stpl_status_t;

  function automatic logic [7:0] host_tag(input logic [3:0] i);
    case (i)
      4'd0: host_tag = "S"; 4'd1: host_tag = "i"; 4'd2: host_tag = "G";
      4'd3: host_tag = "n"; 4'd4: host_tag = "V"; 4'd5: host_tag = "1";
      4'd6: host_tag = "H"; 4'd7: host_tag = "o"; 4'd8: host_tag = "s";
      default: host_tag = "t";
    endcase
  endfunction

  function automatic logic [7:0] reply_tag(input logic [3:0] i, input logic ok);
    case (i)
      4'd0: reply_tag = "S"; 4'd1: reply_tag = "i"; 4'd2: reply_tag = "G";
      4'd3: reply_tag = "n"; 4'd4: reply_tag = "V"; 4'd5: reply_tag = "1";
      4'd6: reply_tag = "D"; 4'd7: reply_tag = "e";
      4'd8: reply_tag = ok ? "O" : "E";
      default: reply_tag = ok ? "K" : "r";
    endcase
  endfunction
endpackage
`default_nettype wire

@@ sv/stpl_ctrl.sv @@
// controller state machine
`default_nettype none
module stpl_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  opcode,
  input  wire stpl_pkg::stpl_status_t status,
  output stpl_pkg::stpl_cmd_t        cmd,
  output logic                       busy
);
  import stpl_pkg::*;
  stpl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (opcode == OP_READ) state_next = ST_READ;
          else if (status.packet_done) state_next = ST_PARSE;
        end
      end
      ST_PARSE: state_next = status.do_scan ? ST_SCAN : ST_REPLY;
      ST_SCAN: begin
        if (status.scan_done) state_next = status.scan_ok ? ST_CLEAR : ST_REPLY;
      end
      ST_CLEAR: if (status.clear_done) state_next = ST_REPLY;
      ST_REPLY: if (status.reply_done) state_next = ST_IDLE;
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        cmd.store_byte = start && (opcode == OP_BYTE);
        cmd.read_entry = start && (opcode == OP_READ);
      end
      ST_PARSE: begin
        cmd.parse = 1'b1;
        cmd.scan_start = status.do_scan;
        cmd.reply_start = !status.do_scan;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.reply_start = status.scan_done && !status.scan_ok;
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        cmd.reply_start = status.clear_done;
      end
      ST_REPLY: cmd.reply_step = 1'b1;
      ST_READ: ;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ sv/stpl_datapath.sv @@
// packet store, entry tables, present marks and reply generation
`default_nettype none
module stpl_datapath #(
  parameter int TABLE_DEPTH = stpl_pkg::TableDepthDefault,
  parameter int PACKET_BYTES = stpl_pkg::PacketBytesDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire stpl_pkg::stpl_cmd_t   cmd,
  input  wire logic [7:0]            rx_byte,
  input  wire logic [6:0]            read_index,
  output stpl_pkg::stpl_status_t     status,
  output logic                       strobe,
  output logic [7:0]                 reply_byte,
  output logic                       reply_last,
  output logic                       packet_accepted,
  output logic                       sequence_complete,
  output logic [31:0]                entry_frequency,
  output logic [7:0]                 entry_gain,
  output logic [31:0]                entry_dwell,
  output logic                       entry_present,
  output logic [7:0]                 entry_total
);
  import stpl_pkg::*;
  localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int HdrBytes = 22;

  // raw packet store, one byte written or read a cycle
  logic [7:0] pkt [PACKET_BYTES];
  // copy of the leading bytes for parsing
  logic [7:0] hdr [HdrBytes];
  logic [7:0] pkt_rd;
  logic [5:0] rd_pos, rd_addr;
  logic shifted;
  logic [5:0] byte_position;
  logic [7:0] total_count;
  logic [TABLE_DEPTH-1:0] present;
  logic [31:0] freq_mem [TABLE_DEPTH];
  logic [7:0]  gain_mem [TABLE_DEPTH];
  logic [31:0] dwell_mem [TABLE_DEPTH];

  logic accepted, complete;
  logic [7:0] cnt;
  logic [7:0] scan_pos;
  logic [5:0] reply_pos;

  // aligned view of the header bytes
  logic [7:0] al [HdrBytes-1];
  logic shift;
  always_comb begin
    shift = (hdr[0] != host_tag(4'd0));
    for (int i = 0; i < HdrBytes - 1; i++) begin
      if (shift) al[i] = hdr[i+1];
      else al[i] = hdr[i];
    end
  end

  logic match, acc_now;
  logic [7:0] a_idx, a_cnt;
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < PreambleLen; i++)
      if (al[i] != host_tag(4'(i))) match = 1'b0;
    a_idx = al[10];
    a_cnt = al[11];
    acc_now = match && ({1'b0, a_idx} < 9'(TABLE_DEPTH)) && ({1'b0, a_cnt} <= 9'(TABLE_DEPTH));
  end

  wire [TW-1:0] sp = scan_pos[TW-1:0];

  // fetch the byte for the next reply position, last byte never moves
  always_comb begin
    rd_pos = reply_pos + 6'd1;
    rd_addr = (shifted && rd_pos != 6'(PACKET_BYTES - 1)) ? rd_pos + 6'd1 : rd_pos;
  end

  always_ff @(posedge clk) begin
    if (cmd.store_byte) pkt[byte_position] <= rx_byte;
    pkt_rd <= pkt[rd_addr];
  end

  always_comb begin
    status.packet_done = (byte_position == 6'(PACKET_BYTES - 1));
    status.do_scan = acc_now && ((a_cnt == 8'd0) || ({1'b0, a_idx} + 9'd1 >= {1'b0, a_cnt}));
    status.scan_done = (scan_pos >= cnt) || !present[sp];
    status.scan_ok = (scan_pos >= cnt);
    status.clear_done = (scan_pos + 8'd1 >= cnt) || (cnt == 8'd0);
    status.reply_done = (reply_pos == 6'(PACKET_BYTES - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      total_count <= '0;
      present <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cmd.store_byte) begin
        if (byte_position < 6'(HdrBytes)) hdr[byte_position[4:0]] <= rx_byte;
        byte_position <= status.packet_done ? 6'd0 : byte_position + 6'd1;
      end
      if (cmd.parse) begin
        accepted <= acc_now;
        complete <= 1'b0;
        cnt <= a_cnt;
        scan_pos <= '0;
        shifted <= shift;
        if (acc_now) begin
          present[a_idx[TW-1:0]] <= 1'b1;
          total_count <= a_cnt;
          freq_mem[a_idx[TW-1:0]] <= {al[15], al[14], al[13], al[12]};
          gain_mem[a_idx[TW-1:0]] <= al[16];
          dwell_mem[a_idx[TW-1:0]] <= {al[20], al[19], al[18], al[17]};
        end
      end
      if (cmd.scan_step) begin
        if (!status.scan_done) scan_pos <= scan_pos + 8'd1;
        else if (status.scan_ok) begin
          complete <= 1'b1;
          scan_pos <= '0;
        end
      end
      if (cmd.clear_step && cnt != 8'd0) begin
        present[sp] <= 1'b0;
        scan_pos <= scan_pos + 8'd1;
      end
      if (cmd.reply_start) reply_pos <= '0;
      if (cmd.reply_step) begin
        strobe <= 1'b1;
        reply_byte <= (reply_pos < 6'(PreambleLen)) ?
                      reply_tag(reply_pos[3:0], accepted) : pkt_rd;
        reply_last <= status.reply_done;
        packet_accepted <= accepted;
        sequence_complete <= complete;
        entry_frequency <= '0;
        entry_gain <= '0;
        entry_dwell <= '0;
        entry_present <= 1'b0;
        entry_total <= total_count;
        reply_pos <= reply_pos + 6'd1;
      end
      if (cmd.read_entry) begin
        strobe <= 1'b1;
        reply_byte <= '0;
        reply_last <= 1'b1;
        packet_accepted <= 1'b0;
        sequence_complete <= 1'b0;
        entry_total <= total_count;
        if ({1'b0, read_index} < 8'(TABLE_DEPTH)) begin
          entry_frequency <= freq_mem[read_index[TW-1:0]];
          entry_gain <= gain_mem[read_index[TW-1:0]];
          entry_dwell <= dwell_mem[read_index[TW-1:0]];
          entry_present <= present[read_index[TW-1:0]];
        end else begin
          entry_frequency <= '0;
          entry_gain <= '0;
          entry_dwell <= '0;
          entry_present <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/sweep_table_packet_loader_unit.sv @@
// top level of the sweep table packet loader
// usage:
//   command channel: start with opcode, rx_byte, read_index; a beat is taken
//   when start is high and busy is low
//   opcode 0 stores one packet byte; bytes before the last give no result
//   the last byte of a packet starts align and parse, an optional scan of
//   the present marks and clearing of them, then a reply of PACKET_BYTES
//   beats, one per cycle
//   opcode 1 reads one table entry; its single beat comes in the next cycle
//   every result beat is marked by strobe for one cycle, reply_last on the
//   last beat of a run; the receiver cannot stall the reply
//   the scan walks the present marks one entry a cycle and flags completion
//   reset clears byte position, total count and all present marks
//   table data are undefined until written
`default_nettype none
module sweep_table_packet_loader_unit #(
  parameter int TABLE_DEPTH = stpl_pkg::TableDepthDefault,
  parameter int PACKET_BYTES = stpl_pkg::PacketBytesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        opcode,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [6:0]  read_index,
  output logic             strobe,
  output logic [7:0]       reply_byte,
  output logic             reply_last,
  output logic             packet_accepted,
  output logic             sequence_complete,
  output logic [31:0]      entry_frequency,
  output logic [7:0]       entry_gain,
  output logic [31:0]      entry_dwell,
  output logic             entry_present,
  output logic [7:0]       entry_total
);
  import stpl_pkg::*;
  stpl_cmd_t cmd;
  stpl_status_t status;

  // sequencer
  stpl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode),
    .status(status), .cmd(cmd), .busy(busy)
  );

  // storage and reply path
  stpl_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .PACKET_BYTES(PACKET_BYTES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .rx_byte(rx_byte), .read_index(read_index),
    .status(status), .strobe(strobe), .reply_byte(reply_byte),
    .reply_last(reply_last), .packet_accepted(packet_accepted),
    .sequence_complete(sequence_complete), .entry_frequency(entry_frequency),
    .entry_gain(entry_gain), .entry_dwell(entry_dwell),
    .entry_present(entry_present), .entry_total(entry_total)
  );
endmodule
`default_nettype wire

@@ sv/stpl_checker.sv @@
// port level checks for the sweep table packet loader
`default_nettype none
module stpl_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic opcode,
  input wire logic strobe,
  input wire logic reply_last,
  input wire logic packet_accepted,
  input wire logic sequence_complete
);
  a_read_beat: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode |=> strobe && reply_last) else $error("read beat missing");
  a_complete_acc: assert property (@(posedge clk) disable iff (rst)
    strobe && sequence_complete |-> packet_accepted) else $error("complete without accept");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) |-> !strobe) else $error("beat while idle");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && reply_last && !opcode |=> !strobe) else $error("beat after last");
endmodule
bind sweep_table_packet_loader_unit stpl_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
  .strobe(strobe), .reply_last(reply_last), .packet_accepted(packet_accepted),
  .sequence_complete(sequence_complete)
);
`default_nettype wire

@@ verif/sweep_table_packet_loader_checker.sv @@
// checker that predicts and compares the reply and read beats of the packet loader
module sweep_table_packet_loader_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        opcode,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [6:0]  read_index,
  input  wire logic        strobe,
  input  wire logic [7:0]  reply_byte,
  input  wire logic        reply_last,
  input  wire logic        packet_accepted,
  input  wire logic        sequence_complete,
  input  wire logic [31:0] entry_frequency,
  input  wire logic [7:0]  entry_gain,
  input  wire logic [31:0] entry_dwell,
  input  wire logic        entry_present,
  input  wire logic [7:0]  entry_total,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import stpl_pkg::*;

  localparam int Depth = 128;
  localparam int PktLen = 64;
  localparam logic [79:0] HostTag = "SiGnV1Host";
  localparam logic [79:0] OkTag = "SiGnV1DeOK";
  localparam logic [79:0] ErrTag = "SiGnV1DeEr";

  typedef struct {
    logic [7:0]  rbyte;
    logic        last;
    logic        acc;
    logic        comp;
    logic [31:0] freq;
    logic [7:0]  gain;
    logic [31:0] dwell;
    logic        pres;
    logic [7:0]  total;
  } reply_beat_t;

  reply_beat_t beat_q[$];
  logic [7:0]  pkt[PktLen];
  int          pos;
  logic [31:0] freq_tab[Depth];
  logic [7:0]  gain_tab[Depth];
  logic [31:0] dwell_tab[Depth];
  logic        marks[Depth];
  logic [7:0]  total;
  int          errs;

  function automatic logic [7:0] tag_byte(input logic [79:0] tag, input int i);
    return tag[79-8*i -: 8];
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
      errs++;
    end
  endfunction

  // model one accepted command beat, queue the beats it causes
  task automatic predict_beat();
    reply_beat_t e;
    logic match, acc, comp, all;
    int idx, cnt;
    if (opcode == OP_READ) begin
      e = '{8'h00, 1'b1, 1'b0, 1'b0, freq_tab[read_index], gain_tab[read_index],
            dwell_tab[read_index], marks[read_index], total};
      beat_q.push_back(e);
    end else begin
      pkt[pos] = rx_byte;
      if (pos != PktLen - 1) begin
        pos++;
      end else begin
        pos = 0;
        if (pkt[0] != tag_byte(HostTag, 0))
          for (int i = 0; i < PktLen - 1; i++) pkt[i] = pkt[i+1];
        match = 1'b1;
        for (int i = 0; i < 10; i++)
          if (pkt[i] != tag_byte(HostTag, i)) match = 1'b0;
        idx = pkt[10];
        cnt = pkt[11];
        acc = match && idx < Depth && cnt <= Depth;
        comp = 1'b0;
        if (acc) begin
          freq_tab[idx] = {pkt[15], pkt[14], pkt[13], pkt[12]};
          gain_tab[idx] = pkt[16];
          dwell_tab[idx] = {pkt[20], pkt[19], pkt[18], pkt[17]};
          marks[idx] = 1'b1;
          total = cnt[7:0];
          if (cnt == 0 || idx + 1 >= cnt) begin
            all = 1'b1;
            for (int i = 0; i < cnt; i++) if (!marks[i]) all = 1'b0;
            if (all) begin
              for (int i = 0; i < cnt; i++) marks[i] = 1'b0;
              comp = 1'b1;
            end
          end
        end
        for (int i = 0; i < PktLen; i++) begin
          e.rbyte = (i < 10) ? tag_byte(acc ? OkTag : ErrTag, i) : pkt[i];
          e.last = (i == PktLen - 1);
          e.acc = acc;
          e.comp = comp;
          e.freq = '0;
          e.gain = '0;
          e.dwell = '0;
          e.pres = 1'b0;
          e.total = total;
          beat_q.push_back(e);
        end
      end
    end
  endtask

  initial begin
    errs = 0;
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    reply_beat_t e;
    if (rst) begin
      pos = 0;
      total = '0;
      for (int i = 0; i < Depth; i++) begin
        marks[i] = 1'b0;
        freq_tab[i] = '0;
        gain_tab[i] = '0;
        dwell_tab[i] = '0;
      end
      for (int i = 0; i < PktLen; i++) pkt[i] = '0;
      beat_q.delete();
    end else begin
      if (strobe) begin
        if (beat_q.size() == 0) begin
          $display("%0t unexpected beat, expected none actual byte %0h", $realtime,
                   reply_byte);
          errs++;
        end else begin
          e = beat_q.pop_front();
          check_field("reply_byte", e.rbyte, reply_byte);
          check_field("reply_last", e.last, reply_last);
          check_field("packet_accepted", e.acc, packet_accepted);
          check_field("sequence_complete", e.comp, sequence_complete);
          check_field("entry_frequency", e.freq, entry_frequency);
          check_field("entry_gain", e.gain, entry_gain);
          check_field("entry_dwell", e.dwell, entry_dwell);
          check_field("entry_present", e.pres, entry_present);
          check_field("entry_total", e.total, entry_total);
        end
      end
      if (start && !busy) predict_beat();
    end
    pending <= beat_q.size();
    fail_count <= errs;
  end
endmodule

@@ verif/sweep_table_packet_loader_unit_test.sv @@
// stimulus and verdict for the sweep table packet loader
module sweep_table_packet_loader_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import stpl_pkg::*;

  localparam logic [79:0] HostTag = "SiGnV1Host";

  // packet flavors the generator can build
  typedef enum int {PK_GOOD, PK_SHIFTED, PK_BAD_TAG, PK_NOISE} pkt_kind_t;

  logic        clk, rst, start, opcode;
  logic [7:0]  rx_byte;
  logic [6:0]  read_index;
  logic        busy, strobe, reply_last, packet_accepted, sequence_complete;
  logic        entry_present;
  logic [7:0]  reply_byte, entry_gain, entry_total;
  logic [31:0] entry_frequency, entry_dwell;
  int          fail_count, pending;

  // entries written so far; only those may be read back
  bit          written[128];
  int          written_list[$];
  bit          quiet;

  sweep_table_packet_loader_unit DUT (.*);

  sweep_table_packet_loader_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // generous fixed run limit
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  // drive one command beat, sometimes after a random gap, and hold it until busy lets it through
  task automatic send_beat(input logic op, input logic [7:0] b, input logic [6:0] ri);
    bit taken;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    rx_byte <= b;
    read_index <= ri;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    @(negedge clk);
  endtask

  task automatic send_packet(input pkt_kind_t kind, input int idx, input int cnt);
    logic [7:0] p[64];
    logic [31:0] freq, dwell;
    int k;
    freq = $urandom;
    dwell = $urandom;
    for (int i = 0; i < 64; i++) p[i] = $urandom_range(0, 255);
    if (kind != PK_NOISE) begin
      for (int i = 0; i < 10; i++) p[i] = HostTag[79-8*i -: 8];
      p[10] = idx[7:0];
      p[11] = cnt[7:0];
      {p[15], p[14], p[13], p[12]} = freq;
      p[16] = $urandom_range(0, 255);
      {p[20], p[19], p[18], p[17]} = dwell;
    end
    // corrupt one preamble byte
    if (kind == PK_BAD_TAG) begin
      k = $urandom_range(1, 9);
      p[k] = p[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    // leading junk byte makes the block shift the packet down by one
    if (kind == PK_SHIFTED) begin
      for (int i = 63; i > 0; i--) p[i] = p[i-1];
      do p[0] = $urandom_range(0, 255); while (p[0] == "S");
    end
    for (int i = 0; i < 64; i++) send_beat(OP_BYTE, p[i], 7'd0);
    if ((kind == PK_GOOD || kind == PK_SHIFTED) && idx < 128 && cnt <= 128 && !written[idx]) begin
      written[idx] = 1'b1;
      written_list.push_back(idx);
    end
  endtask

  task automatic read_any();
    if (written_list.size() != 0)
      send_beat(OP_READ, 8'h00, written_list[$urandom_range(0, written_list.size() - 1)]);
  endtask

  initial begin
    int order[$];
    int n, j, tmp, choice;
    rst = 1'b1;
    start = 1'b0;
    opcode = OP_BYTE;
    rx_byte = '0;
    read_index = '0;
    quiet = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: table edges, range rejects, count of zero, shifted and broken packets
    send_packet(PK_GOOD, 0, 1);
    send_packet(PK_GOOD, 127, 128);
    send_beat(OP_READ, 8'h00, 7'd127);
    send_beat(OP_READ, 8'h00, 7'd0);
    send_packet(PK_GOOD, 128, 4);
    send_packet(PK_GOOD, 3, 129);
    send_packet(PK_GOOD, 255, 255);
    send_packet(PK_GOOD, 5, 0);
    send_packet(PK_SHIFTED, 2, 3);
    send_packet(PK_BAD_TAG, 1, 2);
    send_packet(PK_NOISE, 0, 0);
    send_packet(PK_GOOD, 1, 2);
    send_packet(PK_GOOD, 0, 2);
    send_packet(PK_GOOD, 1, 2);
    send_beat(OP_READ, 8'h00, 7'd1);
    send_beat(OP_READ, 8'h00, 7'd5);
    start <= 1'b0;

    // hold off until every reply is out
    wait (pending == 0);
    repeat (2) @(negedge clk);

    // random: complete sequences in shuffled order, mixed with loose, broken and noise packets and reads
    for (int op = 0; op < 60; op++) begin
      if (op >= 45) quiet = 1'b1;
      choice = $urandom_range(0, 99);
      if (choice < 45) begin
        n = $urandom_range(1, 4);
        order.delete();
        for (int i = 0; i < n; i++) order.push_back(i);
        for (int i = n - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        foreach (order[i])
          send_packet(($urandom_range(0, 3) == 0) ? PK_SHIFTED : PK_GOOD, order[i], n);
        // a stray packet on top of the sequence now and then
        if ($urandom_range(0, 3) == 0) send_packet(PK_GOOD, n - 1, n);
      end else if (choice < 60) begin
        send_packet(PK_GOOD, $urandom_range(0, 130), $urandom_range(0, 130));
      end else if (choice < 72) begin
        send_packet(($urandom_range(0, 1) == 0) ? PK_BAD_TAG : PK_NOISE,
                    $urandom_range(0, 127), $urandom_range(0, 128));
      end else begin
        read_any();
      end
    end
    start <= 1'b0;

    wait (pending == 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ sim.f @@
sv/stpl_pkg.sv
sv/stpl_ctrl.sv
sv/stpl_datapath.sv
sv/sweep_table_packet_loader_unit.sv
sv/stpl_checker.sv
verif/sweep_table_packet_loader_checker.sv
verif/sweep_table_packet_loader_unit_test.sv
